>>> rtl/core/gbch_pkg.sv
// Shared types, constants and GF(32) checksum helpers for the checksum unit.
package gbch_pkg;

  // Default number of prefix characters held in the buffer.
  localparam int MAX_PREFIX_DEF = 128;

  // Remainder and symbol widths.
  localparam int REM_W = 40;
  localparam int SYM_W = 5;
  localparam int CHAR_W = 8;

  // Input operation codes carried on the input tuser.
  localparam logic [1:0] OP_PREFIX = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic KIND_CHECKSUM = 1'b0;
  localparam logic KIND_VERDICT  = 1'b1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_INVALID = 2'd0;
  localparam logic [1:0] VERDICT_BECH32  = 2'd1;
  localparam logic [1:0] VERDICT_BECH32M = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_VARIANT = 1'b1;

  // Mode values.
  localparam logic MODE_CREATE = 1'b0;

  // Final XOR constants.
  localparam logic [REM_W-1:0] BECH32_CONST  = 40'h00_0000_0001;
  localparam logic [REM_W-1:0] BECH32M_CONST = 40'h00_2bc8_30a3;

  // ASCII bounds used to lowercase prefix characters.
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;

  // Generator terms, one for each bit of the symbol shifted out.
  localparam logic [REM_W-1:0] GEN0 = 40'hf0_732d_c147;
  localparam logic [REM_W-1:0] GEN1 = 40'ha8_b6df_a68e;
  localparam logic [REM_W-1:0] GEN2 = 40'h19_3fab_c83c;
  localparam logic [REM_W-1:0] GEN3 = 40'h32_2fd3_b451;
  localparam logic [REM_W-1:0] GEN4 = 40'h64_0f37_688b;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HI,
    S_ZERO,
    S_LO,
    S_DATA,
    S_PAD,
    S_EMIT
  } state_t;

  // One polymod step: shift in a symbol and reduce by the generator.
  function automatic logic [REM_W-1:0] fold_step(input logic [REM_W-1:0] rem,
                                                 input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] top;
    logic [REM_W-1:0] acc;
    top = rem[REM_W-1 -: SYM_W];
    acc = {rem[REM_W-SYM_W-1:0], sym};
    if (top[0]) acc = acc ^ GEN0;
    if (top[1]) acc = acc ^ GEN1;
    if (top[2]) acc = acc ^ GEN2;
    if (top[3]) acc = acc ^ GEN3;
    if (top[4]) acc = acc ^ GEN4;
    return acc;
  endfunction

  // Charset letter of a 5-bit symbol.
  function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] sym);
    logic [CHAR_W-1:0] c;
    case (sym)
      5'd0:  c = "q";
      5'd1:  c = "p";
      5'd2:  c = "z";
      5'd3:  c = "r";
      5'd4:  c = "y";
      5'd5:  c = "9";
      5'd6:  c = "x";
      5'd7:  c = "8";
      5'd8:  c = "g";
      5'd9:  c = "f";
      5'd10: c = "2";
      5'd11: c = "t";
      5'd12: c = "v";
      5'd13: c = "d";
      5'd14: c = "w";
      5'd15: c = "0";
      5'd16: c = "s";
      5'd17: c = "3";
      5'd18: c = "j";
      5'd19: c = "n";
      5'd20: c = "5";
      5'd21: c = "4";
      5'd22: c = "k";
      5'd23: c = "h";
      5'd24: c = "c";
      5'd25: c = "e";
      5'd26: c = "6";
      5'd27: c = "m";
      5'd28: c = "u";
      5'd29: c = "a";
      5'd30: c = "7";
      default: c = "l";
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/gbch_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gbch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/gf32_bch_checksum_40bit_unit.sv
// Top level of the GF(32) BCH checksum unit with a 40-bit remainder.
//
// Prefix characters are lowercased and written to a prefix RAM at one word per
// cycle. On the first data word or at finish, the prefix expansion is folded
// into the remainder by reading the RAM back twice (high bits, then low bits),
// one character per cycle through the RAM's registered read, with one zero
// symbol folded between the passes. After that, each data word is folded as
// it is accepted. A finish in create mode adds 8 zero-symbol folds, then emits
// 8 checksum words at one per cycle as the output accepts them; in verify mode
// it emits one verdict word. A result register sits on the output, so input
// words are taken while a result waits. Prefix characters beyond MAX_PREFIX
// are dropped and flagged on every result of that message.
module gf32_bch_checksum_40bit_unit #(
  parameter int MAX_PREFIX = gbch_pkg::MAX_PREFIX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] checksum_symbol, [12:5] checksum_char,
                                  // [14:13] verdict, [15] prefix_overflow
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast,  // last
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);

  import gbch_pkg::*;

  localparam int AW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
  localparam int LW = $clog2(MAX_PREFIX + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PREFIX);

  // Control and message state.
  state_t            state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              folded_r, folded_nxt;
  logic              ovf_r, ovf_nxt;
  logic              mode_r, variant_r;
  logic [LW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              fin_r, fin_nxt;
  logic [SYM_W-1:0]  dsym_r, dsym_nxt;
  logic [2:0]        cnt_r, cnt_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [1:0]        out_verdict_r, out_verdict_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_last_r, out_last_nxt;

  // Prefix RAM signals.
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Shared fold unit.
  logic              fold_en;
  logic [SYM_W-1:0]  fold_sym;
  logic [REM_W-1:0]  fold_res;

  logic              in_acc, slot_free, rd_issue, rd_done;
  logic [1:0]        in_op;
  logic [CHAR_W-1:0] in_val;
  logic [CHAR_W-1:0] lc_val;
  logic [REM_W-1:0]  var_const;
  state_t            post_state;

  assign in_op     = in_tuser;
  assign in_val    = in_tdata;
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign rd_issue  = (rd_cnt_r < len_r);
  assign rd_done   = (rd_cnt_r == len_r) && pend_r;
  assign fold_res  = fold_step(rem_r, fold_sym);
  assign var_const = variant_r ? BECH32M_CONST : BECH32_CONST;

  // Lowercase an uppercase ASCII letter.
  always_comb begin
    lc_val = in_val;
    if (in_val >= ASCII_UPPER_A && in_val <= ASCII_UPPER_Z) begin
      lc_val = in_val + ASCII_CASE_OFS;
    end
  end

  // Where the sequencer goes once the prefix has been folded.
  always_comb begin
    if (!fin_r) begin
      post_state = S_DATA;
    end else if (mode_r == MODE_CREATE) begin
      post_state = S_PAD;
    end else begin
      post_state = S_EMIT;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !folded_r && (in_op == OP_DATA || in_op == OP_FINISH)) begin
          state_nxt = (len_r == '0) ? S_ZERO : S_HI;
        end else if (in_acc && folded_r && in_op == OP_FINISH) begin
          state_nxt = (mode_r == MODE_CREATE) ? S_PAD : S_EMIT;
        end
      end
      S_HI: begin
        if (rd_done) begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        state_nxt = (len_r == '0) ? post_state : S_LO;
      end
      S_LO: begin
        if (rd_done) begin
          state_nxt = post_state;
        end
      end
      S_DATA: begin
        state_nxt = S_IDLE;
      end
      S_PAD: begin
        if (cnt_r == 3'd7) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free && (mode_r != MODE_CREATE || cnt_r == 3'd7)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    in_tready       = (state_r == S_IDLE);
    len_nxt         = len_r;
    rem_nxt         = rem_r;
    folded_nxt      = folded_r;
    ovf_nxt         = ovf_r;
    rd_cnt_nxt      = rd_cnt_r;
    pend_nxt        = 1'b0;
    fin_nxt         = fin_r;
    dsym_nxt        = dsym_r;
    cnt_nxt         = cnt_r;
    ram_we          = 1'b0;
    ram_waddr       = len_r[AW-1:0];
    ram_wdata       = lc_val;
    ram_re          = 1'b0;
    ram_raddr       = rd_cnt_r[AW-1:0];
    fold_en         = 1'b0;
    fold_sym        = '0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_sym_nxt     = out_sym_r;
    out_char_nxt    = out_char_r;
    out_verdict_nxt = out_verdict_r;
    out_ovf_nxt     = out_ovf_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        rd_cnt_nxt = '0;
        cnt_nxt    = '0;
        if (in_acc) begin
          case (in_op)
            OP_PREFIX: begin
              if (!folded_r) begin
                if (len_r >= MAX_LEN) begin
                  ovf_nxt = 1'b1;
                end else begin
                  ram_we  = 1'b1;
                  len_nxt = len_r + 1'b1;
                end
              end
            end
            OP_DATA: begin
              fin_nxt  = 1'b0;
              dsym_nxt = in_val[SYM_W-1:0];
              if (folded_r) begin
                fold_en  = 1'b1;
                fold_sym = in_val[SYM_W-1:0];
              end
            end
            OP_FINISH: begin
              fin_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_HI, S_LO: begin
        // Read one character ahead and fold the one that has arrived.
        ram_re = rd_issue;
        if (rd_issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        pend_nxt = rd_issue;
        if (pend_r) begin
          fold_en  = 1'b1;
          fold_sym = (state_r == S_HI) ? {2'b00, ram_rdata[CHAR_W-1 -: 3]}
                                       : ram_rdata[SYM_W-1:0];
        end
        if (rd_done) begin
          rd_cnt_nxt = '0;
          if (state_r == S_LO) begin
            folded_nxt = 1'b1;
          end
        end
      end
      S_ZERO: begin
        fold_en    = 1'b1;
        rd_cnt_nxt = '0;
        if (len_r == '0) begin
          folded_nxt = 1'b1;
        end
      end
      S_DATA: begin
        fold_en  = 1'b1;
        fold_sym = dsym_r;
      end
      S_PAD: begin
        fold_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (mode_r == MODE_CREATE) begin
            out_kind_nxt    = KIND_CHECKSUM;
            out_sym_nxt     = rem_r[REM_W-1 -: SYM_W];
            out_char_nxt    = sym_char(rem_r[REM_W-1 -: SYM_W]);
            out_verdict_nxt = VERDICT_INVALID;
            out_last_nxt    = (cnt_r == 3'd7);
            rem_nxt         = {rem_r[REM_W-SYM_W-1:0], {SYM_W{1'b0}}};
            cnt_nxt         = cnt_r + 1'b1;
          end else begin
            out_kind_nxt = KIND_VERDICT;
            out_sym_nxt  = '0;
            out_char_nxt = '0;
            out_last_nxt = 1'b1;
            if (rem_r == BECH32_CONST) begin
              out_verdict_nxt = VERDICT_BECH32;
            end else if (rem_r == BECH32M_CONST) begin
              out_verdict_nxt = VERDICT_BECH32M;
            end else begin
              out_verdict_nxt = VERDICT_INVALID;
            end
          end
          // The final result of the message clears it for the next one.
          if (mode_r != MODE_CREATE || cnt_r == 3'd7) begin
            len_nxt    = '0;
            rem_nxt    = {{(REM_W-1){1'b0}}, 1'b1};
            folded_nxt = 1'b0;
            ovf_nxt    = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Shared fold unit; the last zero fold of create also adds the variant.
    if (fold_en) begin
      rem_nxt = fold_res;
      if (state_r == S_PAD && cnt_r == 3'd7) begin
        rem_nxt = fold_res ^ var_const;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      rem_r       <= {{(REM_W-1){1'b0}}, 1'b1};
      folded_r    <= 1'b0;
      ovf_r       <= 1'b0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      folded_r    <= folded_nxt;
      ovf_r       <= ovf_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      variant_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:    mode_r    <= cfg_wdata;
        REG_VARIANT: variant_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dsym_r        <= dsym_nxt;
    out_kind_r    <= out_kind_nxt;
    out_sym_r     <= out_sym_nxt;
    out_char_r    <= out_char_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_ovf_r     <= out_ovf_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Prefix character buffer.
  gbch_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_PREFIX)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ovf_r, out_verdict_r, out_char_r, out_sym_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
